FILE: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // action codes carried in tuser
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_COLOR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [7:0]  NEWLINE_CODE  = 8'h0A;
  localparam logic [7:0]  BLANK_CHAR    = 8'h20;
  localparam logic [7:0]  DEFAULT_COLOR = 8'h70;
  localparam logic [15:0] BLANK_CELL    = {DEFAULT_COLOR, BLANK_CHAR};

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RESP  = 3'b100
  } tcw_state_e;

  typedef struct packed {
    logic accept;    // take the input word, do its memory access
    logic clr_we;    // write one blank cell of the clearing sweep
    logic load_out;  // load the output register
  } tcw_cmd_t;

  typedef struct packed {
    logic wrap;      // last accepted word wrapped the screen
    logic clr_last;  // sweep is at its last cell
  } tcw_sts_t;

endpackage

FILE: hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: accept, respond and screen-clear sequencing, output valid.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  input  tcw_pkg::tcw_sts_t sts_i,
  output tcw_pkg::tcw_cmd_t cmd_o
);
  import tcw_pkg::*;

  tcw_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    s_tready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = sts_i.wrap ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell memory, cursor, active attribute, clear counter and output register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcw_pkg::tcw_cmd_t cmd_i,
  output tcw_pkg::tcw_sts_t sts_o,
  input  logic [1:0]        action_i,
  input  logic [7:0]        char_code_i,
  input  logic [7:0]        color_value_i,
  input  logic [4:0]        read_row_i,
  input  logic [6:0]        read_col_i,
  output logic [15:0]       cell_data_o,
  output logic [4:0]        cursor_row_out_o,
  output logic [6:0]        cursor_col_out_o,
  output logic              screen_cleared_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned AW    = $clog2(CELLS);

  logic [15:0]   mem [CELLS];

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [7:0]    color_q, color_d;
  logic [AW-1:0] clr_cnt_q;
  logic          wrap_q, hit_q;
  logic [15:0]   rd_q;

  logic [15:0]   out_cell_q;
  logic [4:0]    out_row_q;
  logic [6:0]    out_col_q;
  logic          out_clr_q;

  logic          we, re, advance, wrap;
  logic [6:0]    rrow_ext;
  logic [7:0]    rcol_ext;
  logic          in_range;
  logic [AW-1:0] cur_addr, rd_addr, wr_addr;
  logic [15:0]   wr_data;
  logic [RW+4:0] row_wide;
  logic [CW+6:0] col_wide;

  assign rrow_ext = {2'b00, read_row_i};
  assign rcol_ext = {1'b0, read_col_i};
  assign in_range = (rrow_ext < 7'(ROWS)) && (rcol_ext < 8'(COLS));

  assign cur_addr = AW'(row_q) * AW'(COLS) + AW'(col_q);
  assign rd_addr  = AW'(rrow_ext[RW-1:0]) * AW'(COLS) + AW'(rcol_ext[CW-1:0]);

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    color_d = color_q;
    we      = 1'b0;
    re      = 1'b0;
    advance = 1'b0;
    wrap    = 1'b0;
    if (cmd_i.accept) begin
      case (action_i)
        ACT_PUT: begin
          if (char_code_i == NEWLINE_CODE) begin
            advance = 1'b1;
          end else begin
            we = 1'b1;
            if (col_q == CW'(COLS - 1)) begin
              advance = 1'b1;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
        end
        ACT_COLOR: begin
          color_d = color_value_i;
        end
        ACT_READ: begin
          re = in_range;
        end
        default: begin
        end
      endcase
      if (advance) begin
        col_d = '0;
        if (row_q == RW'(ROWS - 1)) begin
          row_d   = '0;
          wrap    = 1'b1;
          color_d = DEFAULT_COLOR;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
    end
  end

  assign wr_addr = cmd_i.clr_we ? clr_cnt_q : cur_addr;
  assign wr_data = cmd_i.clr_we ? BLANK_CELL : {color_q, char_code_i};

  always_ff @(posedge clk_i) begin
    if (we || cmd_i.clr_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign sts_o.wrap     = wrap_q;
  assign sts_o.clr_last = (clr_cnt_q == AW'(CELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      color_q   <= DEFAULT_COLOR;
      clr_cnt_q <= '0;
      wrap_q    <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      color_q <= color_d;
      if (cmd_i.clr_we) begin
        clr_cnt_q <= sts_o.clr_last ? '0 : clr_cnt_q + 1'b1;
      end
      if (cmd_i.accept) begin
        wrap_q <= wrap;
        hit_q  <= re;
      end
    end
  end

  // cursor reported at the field widths
  assign row_wide = {5'b0, row_q};
  assign col_wide = {7'b0, col_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_cell_q <= hit_q ? rd_q : 16'h0000;
      out_row_q  <= row_wide[4:0];
      out_col_q  <= col_wide[6:0];
      out_clr_q  <= wrap_q;
    end
  end

  assign cell_data_o      = out_cell_q;
  assign cursor_row_out_o = out_row_q;
  assign cursor_col_out_o = out_col_q;
  assign screen_cleared_o = out_clr_q;

endmodule

FILE: hw/rtl/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text console: cell store with cursor, put/color/read actions, one result
// word per input word.
// ----------------------------------------------------------------------------
// Channel  Dir  Bus          Contents
// s_axis   in   tdata[31:0]  char_code, color_value, read_row, read_col
//               tuser[1:0]   action
// m_axis   out  tdata[31:0]  cell_data, cursor_row_out, cursor_col_out,
//                            screen_cleared
//
// The accept cycle of a word does the cell memory access; the response state
// then loads the output register. One word is in work at a time.
// A stalled output holds the block in its response cycle.
// After reset, and after any word that wraps the screen, a clearing sweep
// writes ROWS*COLS blank cells, one per cycle (2000 at 25x80); no word is
// accepted during it.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] char_code, [15:8] color_value, [20:16] read_row, [27:21] read_col
  input  logic [31:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] cell_data, [20:16] cursor_row_out, [27:21] cursor_col_out,
  // [28] screen_cleared
  output logic [31:0] m_axis_tdata
);
  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_sts_t    sts;
  logic [15:0] cell_data;
  logic [4:0]  cursor_row_out;
  logic [6:0]  cursor_col_out;
  logic        screen_cleared;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (s_axis_tuser),
    .char_code_i      (s_axis_tdata[7:0]),
    .color_value_i    (s_axis_tdata[15:8]),
    .read_row_i       (s_axis_tdata[20:16]),
    .read_col_i       (s_axis_tdata[27:21]),
    .cell_data_o      (cell_data),
    .cursor_row_out_o (cursor_row_out),
    .cursor_col_out_o (cursor_col_out),
    .screen_cleared_o (screen_cleared)
  );

  assign m_axis_tdata = {3'b000, screen_cleared, cursor_col_out, cursor_row_out, cell_data};

endmodule

FILE: hw/rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console cell writer, bound to the top.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one word in work at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in work");

  // a wrap reports the home cursor and no cell
  a_wrap_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[28] |-> (m_axis_tdata[27:0] == 28'd0))
    else $error("wrap result with non-home cursor or cell data");

  // reported column stays on the screen
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[27:21]) < COLS))
    else $error("cursor column beyond screen width");

endmodule

bind text_console_cell_writer tcw_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_tcw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/tb_text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer
// Stream-level test of the text console: puts, newlines, color changes and
// cell reads go in through a bursty driver; a scoreboard predicts each result
// word from its own copy of screen, cursor and attribute, and checks the
// returned words in order while the output side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam logic [1:0] ACT_NONE = 2'd3;  // unused action code, ignored by the block
  localparam int WORD_TARGET = 1150;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [7:0] color_value;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } con_word_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        cleared;
  } con_resp_t;

  typedef struct {
    con_word_t w;
    bit        hold;  // wait for every outstanding result before sending
  } con_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        m_ready = 1'b0;
  con_word_t   cur_word = '0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;

  assign s_axis_tdata = {4'b0, cur_word.read_col, cur_word.read_row,
                         cur_word.color_value, cur_word.char_code};
  assign s_axis_tuser = cur_word.action;

  always #4 clk_i = ~clk_i;

  text_console_cell_writer #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // console predictor
  // --------------------------------------------------------------------------
  logic [15:0] scr_cells [ROWS*COLS];
  int          crs_row = 0;
  int          crs_col = 0;
  logic [7:0]  cur_attr;

  function automatic void console_clear();
    for (int i = 0; i < ROWS*COLS; i++) scr_cells[i] = BLANK_CELL;
    cur_attr = DEFAULT_COLOR;
  endfunction

  // returns 1 when the cursor ran off the last row and the screen was blanked
  function automatic bit console_newline();
    crs_col = 0;
    crs_row++;
    if (crs_row >= ROWS) begin
      crs_row = 0;
      console_clear();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic con_resp_t console_apply(con_word_t w);
    con_resp_t r;
    r = '0;
    case (w.action)
      ACT_PUT: begin
        if (w.char_code == NEWLINE_CODE) begin
          r.cleared = console_newline();
        end else begin
          scr_cells[crs_row*COLS + crs_col] = {cur_attr, w.char_code};
          crs_col++;
          if (crs_col >= COLS) r.cleared = console_newline();
        end
      end
      ACT_COLOR: cur_attr = w.color_value;
      ACT_READ: begin
        if (int'(w.read_row) < ROWS && int'(w.read_col) < COLS)
          r.cell_data = scr_cells[int'(w.read_row)*COLS + int'(w.read_col)];
      end
      default: ;
    endcase
    r.row = crs_row[4:0];
    r.col = crs_col[6:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // queues and counters
  // --------------------------------------------------------------------------
  con_item_t words_to_send[$];
  con_resp_t resp_expected[$];
  int        words_queued = 0;
  int        words_accepted = 0;
  int        n_useful = 0;
  int        n_errors = 0;
  bit        next_hold = 1'b0;
  logic      in_taken = 1'b0;

  task automatic flag_mismatch(string what, int unsigned want_v, int unsigned got_v);
    n_errors++;
    if (n_errors <= 10)
      $display("%0t: %s expected %0h, got %0h", $time, what, want_v, got_v);
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of words with random gaps
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk_i) begin : p_drive
    con_item_t nxt;
    bit        go;
    if (rst_ni && (!s_valid || in_taken)) begin
      go = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (words_to_send.size() > 0 &&
                   !(words_to_send[0].hold && resp_expected.size() != 0)) begin
        nxt = words_to_send.pop_front();
        go = 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (go) cur_word <= nxt.w;
      s_valid <= go;
    end
  end

  // receiver: stall mode and pattern reloaded when the current pattern runs out
  int          rdy_left = 0;
  int          rdy_mode = 0;
  logic [15:0] rdy_pat;

  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_left = 16;
      rdy_mode = $urandom_range(0, 2);
      rdy_pat = 16'($urandom);
    end
    rdy_left--;
    case (rdy_mode)
      0:       m_ready <= 1'b1;
      1:       m_ready <= rdy_pat[rdy_left];
      default: m_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // scoreboard: check result words, predict on each accepted input word
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : p_check
    con_resp_t got;
    con_resp_t want;
    if (rst_ni) begin
      in_taken <= s_valid && s_axis_tready;
      if (m_axis_tvalid && m_ready) begin
        got.cell_data = m_axis_tdata[15:0];
        got.row       = m_axis_tdata[20:16];
        got.col       = m_axis_tdata[27:21];
        got.cleared   = m_axis_tdata[28];
        if (resp_expected.size() == 0) begin
          flag_mismatch("unexpected result word", 0, m_axis_tdata);
        end else begin
          want = resp_expected.pop_front();
          if (got.cell_data != want.cell_data)
            flag_mismatch("cell_data", 32'(want.cell_data), 32'(got.cell_data));
          if (got.row != want.row)
            flag_mismatch("cursor_row", 32'(want.row), 32'(got.row));
          if (got.col != want.col)
            flag_mismatch("cursor_col", 32'(want.col), 32'(got.col));
          if (got.cleared != want.cleared)
            flag_mismatch("screen_cleared", 32'(want.cleared), 32'(got.cleared));
        end
      end
      if (s_valid && s_axis_tready) begin
        resp_expected.push_back(console_apply(cur_word));
        words_accepted <= words_accepted + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic con_word_t any_word(logic [1:0] act);
    con_word_t w;
    w.action      = act;
    w.char_code   = 8'($urandom);
    w.color_value = 8'($urandom);
    w.read_row    = 5'($urandom);
    w.read_col    = 7'($urandom);
    return w;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] ch;
    do ch = 8'($urandom); while (ch == NEWLINE_CODE);
    return ch;
  endfunction

  task automatic queue_word(con_word_t w);
    con_item_t it;
    it.w = w;
    it.hold = next_hold;
    next_hold = 1'b0;
    words_to_send.push_back(it);
    words_queued++;
    if (w.action != ACT_NONE) n_useful++;
  endtask

  task automatic send_put(logic [7:0] ch);
    con_word_t w;
    w = any_word(ACT_PUT);
    w.char_code = ch;
    queue_word(w);
  endtask

  task automatic send_color(logic [7:0] c);
    con_word_t w;
    w = any_word(ACT_COLOR);
    w.color_value = c;
    queue_word(w);
  endtask

  task automatic send_read(int r, int c);
    con_word_t w;
    w = any_word(ACT_READ);
    w.read_row = r[4:0];
    w.read_col = c[6:0];
    queue_word(w);
  endtask

  // mostly reads near the top rows, where text tends to be
  task automatic rand_read();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: send_read($urandom_range(0, $urandom_range(0, ROWS-1)),
                                  $urandom_range(0, COLS-1));
      6: send_read(ROWS-1, $urandom_range(0, 1) ? COLS-1 : $urandom_range(0, COLS-1));
      7: send_read($urandom_range(ROWS, 31), $urandom_range(0, 127));
      8: send_read($urandom_range(0, 31), $urandom_range(COLS, 127));
      default: send_read($urandom_range(0, 31), $urandom_range(0, 127));
    endcase
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || resp_expected.size() != 0) @(negedge clk_i);
  endtask

  // drain, then drive the cursor to the last row and type to its end so the
  // final put wraps the screen; then check blanking and the attribute reset
  task automatic wrap_by_put();
    int nl;
    wait_drained();
    nl = ROWS - 1 - crs_row;
    repeat (nl) send_put(NEWLINE_CODE);
    send_color(8'($urandom));
    repeat (nl > 0 ? COLS : COLS - crs_col) send_put(text_char());
    send_read(ROWS-1, COLS-1);
    send_read(0, 0);
    send_put(text_char());
    send_read(0, 0);
  endtask

  initial begin : p_main
    con_word_t w;
    int        plans_done;
    console_clear();

    // directed: reset contents, read bounds, extreme codes, unused action
    send_read(0, 0);
    send_read(ROWS-1, COLS-1);
    send_read(ROWS, 0);
    send_read(0, COLS);
    send_read(31, 127);
    send_put(8'h00);
    send_color(8'hFF);
    send_put(8'hFF);
    send_color(8'h00);
    send_put(8'h41);
    send_read(0, 0);
    send_read(0, 1);
    send_read(0, 2);
    w = '1;
    queue_word(w);
    w = '0;
    w.action = ACT_NONE;
    queue_word(w);
    send_put(NEWLINE_CODE);
    send_put(NEWLINE_CODE);
    send_color(8'hA5);
    send_put(8'h5A);
    send_read(2, 0);
    send_read(1, 0);
    w = any_word(ACT_COLOR);
    w.color_value = 8'h0F;
    w.read_row = '1;
    w.read_col = '1;
    w.char_code = NEWLINE_CODE;
    queue_word(w);
    send_put(8'h7E);
    send_read(2, 1);

    plans_done = 0;
    while (n_useful < WORD_TARGET) begin
      if (plans_done < 3 && n_useful >= plans_done * 400) begin
        wrap_by_put();
        plans_done++;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          if ($urandom_range(0, 2) == 0) send_color(8'($urandom));
          repeat ($urandom_range(0, 20)) send_put(text_char());
          send_put(NEWLINE_CODE);
          if ($urandom_range(0, 1)) rand_read();
        end
        8, 9: repeat ($urandom_range(60, 100)) send_put(text_char());
        10, 11, 12, 13: repeat ($urandom_range(1, 4)) rand_read();
        14, 15: repeat ($urandom_range(1, 30)) send_put(NEWLINE_CODE);
        16: next_hold = 1'b1;
        default: repeat ($urandom_range(1, 3)) queue_word(any_word(2'($urandom_range(0, 3))));
      endcase
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (resp_expected.size() != 0)
      flag_mismatch("outstanding results", 0, resp_expected.size());
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
